### rtl/savgol_smoother_7pt_quadratic_macros.svh
// assertion macros for the savitzky-golay smoother
// no dependencies; included by the top level only
`ifndef SAVGOL_SMOOTHER_7PT_QUADRATIC_MACROS_SVH
`define SAVGOL_SMOOTHER_7PT_QUADRATIC_MACROS_SVH

// expression must hold at every edge outside reset
`define SGS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sgs: invariant violated");

// expression must hold at the edge that follows the condition
`define SGS_ASSERT_NEXT(label, clk, cond, expr) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error("sgs: expected state after condition missing");

`endif

### rtl/sgs_pkg.sv
// shared types, constants and the weight table of the smoother
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sgs_pkg;

   // filter geometry
   localparam int TAPS     = 7;
   localparam int WEIGHT_W = 7;
   localparam int DEN      = 42;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // quotient bits resolved per divider stage
   localparam int DIV_BITS = 8;

   // fill counter codes
   localparam logic [2:0] FILL_PRIMED = 3'd6;
   localparam logic [2:0] FILL_FULL   = 3'd7;

   // row codes of the fit
   localparam logic [2:0] ROW_FIRST_EDGE = 3'd0;
   localparam logic [2:0] ROW_CENTER     = 3'd3;
   localparam logic [2:0] ROW_LAST       = 3'd6;
   localparam logic [2:0] TAP_LAST       = 3'd6;

   typedef logic signed [WEIGHT_W-1:0] weight_type;

   // unit weight that passes a sample through the divider unchanged
   localparam weight_type PASS_WEIGHT = 7'sd42;

   // numerators over 42, one row per output position of a window
   localparam weight_type SG_WEIGHT [TAPS][TAPS] = '{
      '{ 7'sd32,  7'sd15,  7'sd3,  -7'sd4, -7'sd6, -7'sd3,  7'sd5  },
      '{ 7'sd15,  7'sd12,  7'sd9,   7'sd6,  7'sd3,  7'sd0, -7'sd3  },
      '{ 7'sd3,   7'sd9,   7'sd12,  7'sd12, 7'sd9,  7'sd3, -7'sd6  },
      '{ -7'sd4,  7'sd6,   7'sd12,  7'sd14, 7'sd12, 7'sd6, -7'sd4  },
      '{ -7'sd6,  7'sd3,   7'sd9,   7'sd12, 7'sd12, 7'sd9,  7'sd3  },
      '{ -7'sd3,  7'sd0,   7'sd3,   7'sd6,  7'sd9,  7'sd12, 7'sd15 },
      '{ 7'sd5,  -7'sd3,  -7'sd6,  -7'sd4,  7'sd3,  7'sd15, 7'sd32 }
   };

   // one job: the rows to run over a window snapshot
   typedef struct packed {
      logic       pass;
      logic [2:0] first_row;
      logic [2:0] span;
      logic       last;
   } job_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic weight_type sg_weight(input logic [2:0] row, input logic [2:0] tap);
      weight_type w;
      w = '0;
      if (row <= ROW_LAST && tap <= TAP_LAST) begin
         w = SG_WEIGHT[row][tap];
      end
      return w;
   endfunction

endpackage

### rtl/sgs_if.sv
// request and response channel interfaces of the smoother
// no dependencies; used by the front, back and top level
`timescale 1ns / 1ps

interface sgs_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           last_in;

   modport source (output valid, sample, last_in, input ready);
   modport sink   (input valid, sample, last_in, output ready);
endinterface

interface sgs_rsp_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] smoothed;
   logic                           last_out;

   modport source (output valid, smoothed, last_out, input ready);
   modport sink   (input valid, smoothed, last_out, output ready);
endinterface

### rtl/sgs_front.sv
// front end: takes sample words, keeps the window and fill count, issues jobs
// depends on sgs_pkg and sgs_req_if
`timescale 1ns / 1ps

module sgs_front #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   sgs_req_if.sink                                     req_chan,
   input  logic                                        queue_full,
   output logic                                        push,
   output sgs_pkg::job_ctl_type                        job_ctl,
   output logic [sgs_pkg::TAPS*SAMPLE_WIDTH-1:0]       job_window
);
   import sgs_pkg::*;

   logic [2:0]                     fill_ff, fill_in;
   logic signed [SAMPLE_WIDTH-1:0] window_ff [TAPS];
   logic signed [SAMPLE_WIDTH-1:0] window_in [TAPS];
   logic                           accept;

   // take a word whenever the job queue has room
   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // classify the word and build the job for it
   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      push      = 1'b0;
      job_ctl   = '0;
      if (accept) begin
         priority if (fill_ff == FILL_FULL) begin
            // steady state: slide and run the centered row, and the right edge rows on last
            for (int j = 0; j < TAPS - 1; j++) begin
               window_in[j] = window_ff[j+1];
            end
            window_in[TAPS-1] = req_chan.sample;
            push              = 1'b1;
            job_ctl.first_row = ROW_CENTER;
            job_ctl.span      = req_chan.last_in ? (ROW_LAST - ROW_CENTER) : 3'd0;
            job_ctl.last      = req_chan.last_in;
            fill_in           = req_chan.last_in ? 3'd0 : FILL_FULL;
         end else if (fill_ff == FILL_PRIMED) begin
            // window completes: left edge rows and the center, or all rows on last
            window_in[TAPS-1] = req_chan.sample;
            push              = 1'b1;
            job_ctl.first_row = ROW_FIRST_EDGE;
            job_ctl.span      = req_chan.last_in ? ROW_LAST : ROW_CENTER;
            job_ctl.last      = req_chan.last_in;
            fill_in           = req_chan.last_in ? 3'd0 : FILL_FULL;
         end else begin
            // still filling; a short sequence is passed through on last
            window_in[fill_ff] = req_chan.sample;
            fill_in            = fill_ff + 3'd1;
            if (req_chan.last_in) begin
               push              = 1'b1;
               job_ctl.pass      = 1'b1;
               job_ctl.first_row = ROW_FIRST_EDGE;
               job_ctl.span      = fill_ff;
               job_ctl.last      = 1'b1;
               fill_in           = 3'd0;
            end
         end
      end
   end

   // snapshot of the updated window travels with the job
   always_comb begin
      for (int j = 0; j < TAPS; j++) begin
         job_window[j*SAMPLE_WIDTH +: SAMPLE_WIDTH] = window_in[j];
      end
   end

   // fill counter
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 3'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // window samples, cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TAPS; j++) begin
            window_ff[j] <= '0;
         end
      end else begin
         window_ff <= window_in;
      end
   end

endmodule

### rtl/sgs_job_queue.sv
// short job queue that decouples the front end from the arithmetic back end
// depends on sgs_pkg
`timescale 1ns / 1ps

module sgs_job_queue #(
   parameter int DATA_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [DATA_W-1:0]       push_data,
   input  logic                    pop,
   output logic [DATA_W-1:0]       head_data,
   output sgs_pkg::queue_stat_type stat
);
   import sgs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [DATA_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign head_data  = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_FULL);
   assign stat.empty = (count_ff == '0);

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/sgs_back.sv
// back end: steps through the rows of each job and runs the weighted sum,
// rounding divide by 42 and saturation; depends on sgs_pkg and sgs_rsp_if
`timescale 1ns / 1ps

module sgs_back #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sgs_pkg::job_ctl_type                  head_ctl,
   input  logic [sgs_pkg::TAPS*SAMPLE_WIDTH-1:0] head_window,
   input  logic                                  queue_empty,
   output logic                                  pop,
   sgs_rsp_if.source                             rsp_chan
);
   import sgs_pkg::*;

   localparam int PROD_W     = SAMPLE_WIDTH + WEIGHT_W;
   localparam int SUM_W      = SAMPLE_WIDTH + 9;
   localparam int REM_W      = 6;
   localparam int TRIAL_W    = REM_W + 1;
   localparam int DIV_STAGES = (SAMPLE_WIDTH + DIV_BITS - 1) / DIV_BITS;

   // bias that makes the floor divide round to nearest and the dividend positive
   localparam logic signed [SUM_W-1:0] OFFSET =
      SUM_W'(DEN / 2) + (SUM_W'(DEN) <<< (SAMPLE_WIDTH - 1));
   localparam logic signed [SUM_W-1:0] SAT_LIMIT = SUM_W'(DEN) <<< SAMPLE_WIDTH;
   localparam logic [TRIAL_W-1:0]      DEN_TRIAL = TRIAL_W'(DEN);
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // restoring divide by the constant, up to DIV_BITS quotient bits
   function automatic logic [REM_W+SAMPLE_WIDTH-1:0] div_steps(
      input logic [REM_W-1:0]        rem_i,
      input logic [SAMPLE_WIDTH-1:0] bits_i,
      input int                      nsteps
   );
      logic [REM_W-1:0]        rem;
      logic [SAMPLE_WIDTH-1:0] bits;
      logic [TRIAL_W-1:0]      trial;
      logic                    ge;
      rem  = rem_i;
      bits = bits_i;
      for (int k = 0; k < DIV_BITS; k++) begin
         if (k < nsteps) begin
            trial = {rem, bits[SAMPLE_WIDTH-1]};
            ge    = (trial >= DEN_TRIAL);
            rem   = ge ? REM_W'(trial - DEN_TRIAL) : trial[REM_W-1:0];
            bits  = {bits[SAMPLE_WIDTH-2:0], ge};
         end
      end
      return {rem, bits};
   endfunction

   logic                           en;
   logic                           issue;
   logic                           at_end;
   logic [2:0]                     row;
   logic [2:0]                     off_ff, off_in;

   logic                           s1_valid_ff;
   logic                           s1_last_ff;
   weight_type                     s1_w_ff [TAPS];
   logic signed [SAMPLE_WIDTH-1:0] s1_x_ff [TAPS];

   logic                           s2_valid_ff;
   logic                           s2_last_ff;
   logic signed [PROD_W-1:0]       s2_prod_ff [TAPS];

   logic signed [SUM_W-1:0]        sum_in;

   logic                           dv_valid_ff [DIV_STAGES+1];
   logic                           dv_last_ff  [DIV_STAGES+1];
   logic                           dv_hi_ff    [DIV_STAGES+1];
   logic                           dv_lo_ff    [DIV_STAGES+1];
   logic [REM_W-1:0]               dv_rem_ff   [DIV_STAGES+1];
   logic [SAMPLE_WIDTH-1:0]        dv_bits_ff  [DIV_STAGES+1];

   logic                           out_valid_ff;
   logic                           out_last_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_word_ff, out_word_in;
   logic [SAMPLE_WIDTH-1:0]        quot;

   // whole pipeline moves unless the output word is stuck
   assign en = !out_valid_ff || rsp_chan.ready;

   // row sequencer over the head job
   assign issue  = en && !queue_empty;
   assign at_end = (off_ff == head_ctl.span);
   assign row    = head_ctl.first_row + off_ff;
   assign pop    = issue && at_end;

   always_comb begin
      off_in = off_ff;
      if (issue) begin
         off_in = at_end ? 3'd0 : off_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= 3'd0;
      end else begin
         off_ff <= off_in;
      end
   end

   // stage 1: select weights and latch the window
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= issue;
      end
      if (en) begin
         s1_last_ff <= head_ctl.last && at_end;
         for (int j = 0; j < TAPS; j++) begin
            if (head_ctl.pass) begin
               s1_w_ff[j] <= (3'(j) == row) ? PASS_WEIGHT : '0;
            end else begin
               s1_w_ff[j] <= sg_weight(row, 3'(j));
            end
            s1_x_ff[j] <= head_window[j*SAMPLE_WIDTH +: SAMPLE_WIDTH];
         end
      end
   end

   // stage 2: one small product per tap
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_last_ff <= s1_last_ff;
         for (int j = 0; j < TAPS; j++) begin
            s2_prod_ff[j] <= PROD_W'(s1_w_ff[j]) * PROD_W'(s1_x_ff[j]);
         end
      end
   end

   // stage 3: biased sum and range check
   always_comb begin
      sum_in = OFFSET;
      for (int j = 0; j < TAPS; j++) begin
         sum_in = sum_in + SUM_W'(s2_prod_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= s2_valid_ff;
      end
      if (en) begin
         dv_last_ff[0] <= s2_last_ff;
         dv_hi_ff[0]   <= (sum_in >= SAT_LIMIT);
         dv_lo_ff[0]   <= sum_in[SUM_W-1];
         dv_rem_ff[0]  <= sum_in[SAMPLE_WIDTH+REM_W-1:SAMPLE_WIDTH];
         dv_bits_ff[0] <= sum_in[SAMPLE_WIDTH-1:0];
      end
   end

   // divider stages, up to DIV_BITS quotient bits each
   for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
      localparam int STEPS = (SAMPLE_WIDTH - d * DIV_BITS > DIV_BITS) ?
                             DIV_BITS : SAMPLE_WIDTH - d * DIV_BITS;
      logic [REM_W+SAMPLE_WIDTH-1:0] step_out;

      assign step_out = div_steps(dv_rem_ff[d], dv_bits_ff[d], STEPS);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[d+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[d+1] <= dv_valid_ff[d];
         end
         if (en) begin
            dv_last_ff[d+1] <= dv_last_ff[d];
            dv_hi_ff[d+1]   <= dv_hi_ff[d];
            dv_lo_ff[d+1]   <= dv_lo_ff[d];
            dv_rem_ff[d+1]  <= step_out[REM_W+SAMPLE_WIDTH-1:SAMPLE_WIDTH];
            dv_bits_ff[d+1] <= step_out[SAMPLE_WIDTH-1:0];
         end
      end
   end

   // remove the bias and clamp
   assign quot = dv_bits_ff[DIV_STAGES];

   always_comb begin
      priority if (dv_hi_ff[DIV_STAGES]) begin
         out_word_in = SAMPLE_MAX;
      end else if (dv_lo_ff[DIV_STAGES]) begin
         out_word_in = SAMPLE_MIN;
      end else begin
         out_word_in = {~quot[SAMPLE_WIDTH-1], quot[SAMPLE_WIDTH-2:0]};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_valid_ff[DIV_STAGES];
      end
      if (en) begin
         out_last_ff <= dv_last_ff[DIV_STAGES];
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.smoothed = out_word_ff;
   assign rsp_chan.last_out = out_last_ff;

endmodule

### rtl/savgol_smoother_7pt_quadratic.sv
// channel   | dir | payload                       | role
// req_chan  | in  | sample, last_in               | raw sample words
// rsp_chan  | out | smoothed, last_out            | smoothed words
//
// accepts one sample word per cycle while the queue has room; each smoothed word passes
// stage 1, the product, sum and divider stages and output register. the back end issues
// one row per cycle from the 4-deep job queue unless stalled; a final or window-completing
// sample (up to 7 rows) holds its entry until its last row issues, and req_chan.ready
// drops while the queue is full. synchronous reset empties the queue and pipeline at once.
// a stall on rsp_chan freezes the whole back end; the front keeps taking words until full.
// depends on sgs_pkg, sgs_if, sgs_front, sgs_job_queue, sgs_back and the macro header
`timescale 1ns / 1ps
`include "savgol_smoother_7pt_quadratic_macros.svh"

module savgol_smoother_7pt_quadratic #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   sgs_req_if.sink   req_chan,
   sgs_rsp_if.source rsp_chan
);
   import sgs_pkg::*;

   localparam int JOB_W = $bits(job_ctl_type) + TAPS * SAMPLE_WIDTH;

   logic                           push;
   logic                           pop;
   job_ctl_type                    job_ctl;
   job_ctl_type                    head_ctl;
   logic [TAPS*SAMPLE_WIDTH-1:0]   job_window;
   logic [TAPS*SAMPLE_WIDTH-1:0]   head_window;
   logic [JOB_W-1:0]               head_data;
   queue_stat_type                 q_stat;

   // window keeping and job building
   sgs_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (q_stat.full),
      .push       (push),
      .job_ctl    (job_ctl),
      .job_window (job_window)
   );

   // job queue
   sgs_job_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({job_ctl, job_window}),
      .pop       (pop),
      .head_data (head_data),
      .stat      (q_stat)
   );

   assign head_ctl    = head_data[JOB_W-1:TAPS*SAMPLE_WIDTH];
   assign head_window = head_data[TAPS*SAMPLE_WIDTH-1:0];

   // row sequencing and arithmetic
   sgs_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_ctl    (head_ctl),
      .head_window (head_window),
      .queue_empty (q_stat.empty),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

   // checks across front, queue and back
   `SGS_ASSERT_NEXT(a_reset_clears, clock, reset, q_stat.empty && !rsp_chan.valid)
   `SGS_ASSERT_ALWAYS(a_pop_needs_job, clock, reset, !pop || !q_stat.empty)
   `SGS_ASSERT_ALWAYS(a_push_needs_room, clock, reset, !push || !q_stat.full)

endmodule
